// ===== sv/dnp3lfc_pkg.sv =====
// Package for the DNP3 link frame checker: item and result types,
// protocol constants and the CRC-16/DNP byte update. No dependencies.
package dnp3lfc_pkg;

    localparam int HEADER_BYTES = 10;
    localparam int BLOCK_BYTES  = 16;
    localparam int BIDX_W       = $clog2(BLOCK_BYTES + 1);
    localparam int HIDX_W       = $clog2(HEADER_BYTES + 1);

    localparam logic [7:0]  START_BYTE0 = 8'h05;
    localparam logic [7:0]  START_BYTE1 = 8'h64;
    localparam logic [15:0] CRC_POLY    = 16'hA6BC;
    localparam logic [7:0]  MIN_LENGTH  = 8'd5;

    // Summary status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_START = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_SHORT_LEN = 2'd3;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_begin;
        logic       buffer_end;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [1:0]  status;
        logic [15:0] source_address;
        logic [15:0] destination_address;
        logic [7:0]  link_control;
        logic        is_response;
        logic        header_crc_bad;
        logic        block_crc_bad;
        logic        first_fragment;
        logic        final_fragment;
        logic [7:0]  user_data_count;
    } t_result;

    // One byte through the reflected CRC-16/DNP register (init 0, no final invert).
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== sv/dnp3lfc_ifs.sv =====
// Valid/ready channel interfaces of the DNP3 link frame checker:
// the received byte stream and the result stream. No dependencies.
interface dnp3lfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_begin;
    logic       buffer_end;

    modport source (output valid, output data_byte, output frame_begin,
                    output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input frame_begin,
                    input buffer_end, output ready);
endinterface

interface dnp3lfc_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  status;
    logic [15:0] source_address;
    logic [15:0] destination_address;
    logic [7:0]  link_control;
    logic        is_response;
    logic        header_crc_bad;
    logic        block_crc_bad;
    logic        first_fragment;
    logic        final_fragment;
    logic [7:0]  user_data_count;

    modport source (output valid, output kind, output payload_byte, output status,
                    output source_address, output destination_address,
                    output link_control, output is_response, output header_crc_bad,
                    output block_crc_bad, output first_fragment, output final_fragment,
                    output user_data_count, input ready);
    modport sink   (input valid, input kind, input payload_byte, input status,
                    input source_address, input destination_address,
                    input link_control, input is_response, input header_crc_bad,
                    input block_crc_bad, input first_fragment, input final_fragment,
                    input user_data_count, output ready);
endinterface

// ===== sv/dnp3lfc_parser.sv =====
// Frame parser state and per-byte next-state logic of the DNP3 link frame checker.
// Depends on dnp3lfc_pkg.
module dnp3lfc_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  dnp3lfc_pkg::t_in_item i_item,
    output logic                  o_res_vld,
    output dnp3lfc_pkg::t_result  o_res
);
    import dnp3lfc_pkg::*;

    localparam logic [2:0] PH_START0 = 3'd0;
    localparam logic [2:0] PH_START1 = 3'd1;
    localparam logic [2:0] PH_HEADER = 3'd2;
    localparam logic [2:0] PH_BLOCK  = 3'd3;
    localparam logic [2:0] PH_CRC_LO = 3'd4;
    localparam logic [2:0] PH_CRC_HI = 3'd5;
    localparam logic [2:0] PH_IDLE   = 3'd6;

    logic [2:0]        r_phase, n_phase, c_phase;
    logic [HIDX_W-1:0] r_hidx,  n_hidx,  c_hidx;
    logic [15:0]       r_crc,   n_crc,   c_crc;
    logic [7:0]        r_low,   n_low,   c_low;
    logic [7:0]        r_len,   n_len,   c_len;
    logic [7:0]        r_ctl,   n_ctl,   c_ctl;
    logic [15:0]       r_dst,   n_dst,   c_dst;
    logic [15:0]       r_src,   n_src,   c_src;
    logic [7:0]        r_rem,   n_rem,   c_rem;
    logic [BIDX_W-1:0] r_bidx,  n_bidx,  c_bidx;
    logic [1:0]        r_err,   n_err,   c_err;
    logic [1:0]        r_tb,    n_tb,    c_tb;

    logic [7:0]  b;
    logic        do_sum, do_pay;
    logic [1:0]  sum_st;
    logic [15:0] crc_b;
    logic        crc_ok;
    logic [7:0]  user_cnt;

    assign b        = i_item.data_byte;
    assign crc_b    = crc_feed(c_crc, b);
    assign crc_ok   = ({b, c_low} == ~c_crc);
    assign user_cnt = c_len - MIN_LENGTH;

    // frame_begin restarts the parser before the byte is looked at
    always_comb begin
        if (i_item.frame_begin) begin
            c_phase = PH_START0;
            c_hidx  = '0;
            c_crc   = '0;
            c_low   = '0;
            c_len   = '0;
            c_ctl   = '0;
            c_dst   = '0;
            c_src   = '0;
            c_rem   = '0;
            c_bidx  = '0;
            c_err   = '0;
            c_tb    = '0;
        end else begin
            c_phase = r_phase;
            c_hidx  = r_hidx;
            c_crc   = r_crc;
            c_low   = r_low;
            c_len   = r_len;
            c_ctl   = r_ctl;
            c_dst   = r_dst;
            c_src   = r_src;
            c_rem   = r_rem;
            c_bidx  = r_bidx;
            c_err   = r_err;
            c_tb    = r_tb;
        end
    end

    always_comb begin
        n_phase = c_phase;
        n_hidx  = c_hidx;
        n_crc   = c_crc;
        n_low   = c_low;
        n_len   = c_len;
        n_ctl   = c_ctl;
        n_dst   = c_dst;
        n_src   = c_src;
        n_rem   = c_rem;
        n_bidx  = c_bidx;
        n_err   = c_err;
        n_tb    = c_tb;
        do_sum  = 1'b0;
        do_pay  = 1'b0;
        sum_st  = ST_OK;

        unique case (c_phase)
            PH_START0: begin
                n_hidx = HIDX_W'(1);
                if (b != START_BYTE0) begin
                    do_sum  = 1'b1;
                    sum_st  = ST_BAD_START;
                    n_phase = PH_IDLE;
                end else begin
                    n_crc   = crc_b;
                    n_phase = PH_START1;
                end
            end
            PH_START1: begin
                n_hidx = HIDX_W'(2);
                if (b != START_BYTE1) begin
                    do_sum  = 1'b1;
                    sum_st  = ST_BAD_START;
                    n_phase = PH_IDLE;
                end else begin
                    n_crc   = crc_b;
                    n_phase = PH_HEADER;
                end
            end
            PH_HEADER: begin
                if (c_hidx < HIDX_W'(8)) begin
                    n_crc = crc_b;
                end
                unique case (c_hidx)
                    HIDX_W'(2): n_len = b;
                    HIDX_W'(3): n_ctl = b;
                    HIDX_W'(4): n_dst = {c_dst[15:8], b};
                    HIDX_W'(5): n_dst = {b, c_dst[7:0]};
                    HIDX_W'(6): n_src = {c_src[15:8], b};
                    HIDX_W'(7): n_src = {b, c_src[7:0]};
                    HIDX_W'(8): n_low = b;
                    default: ;
                endcase
                n_hidx = c_hidx + HIDX_W'(1);
                if (c_hidx >= HIDX_W'(HEADER_BYTES - 1)) begin
                    if (!crc_ok) begin
                        n_err[0] = 1'b1;
                    end
                    if (c_len < MIN_LENGTH) begin
                        do_sum  = 1'b1;
                        sum_st  = ST_SHORT_LEN;
                        n_phase = PH_IDLE;
                    end else begin
                        n_rem = user_cnt;
                        if (user_cnt == 8'd0) begin
                            do_sum  = 1'b1;
                            sum_st  = ST_OK;
                            n_phase = PH_IDLE;
                        end else begin
                            n_phase = PH_BLOCK;
                            n_bidx  = '0;
                            n_crc   = '0;
                        end
                    end
                end
            end
            PH_BLOCK: begin
                n_crc = crc_b;
                // first user byte is the transport header
                if (c_rem == user_cnt) begin
                    n_tb = {b[7], b[6]};
                end else begin
                    do_pay = 1'b1;
                end
                n_bidx = c_bidx + BIDX_W'(1);
                n_rem  = c_rem - 8'd1;
                if (n_bidx >= BIDX_W'(BLOCK_BYTES) || n_rem == 8'd0) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_low   = b;
                n_phase = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                if (!crc_ok) begin
                    n_err[1] = 1'b1;
                end
                if (c_rem == 8'd0) begin
                    do_sum  = 1'b1;
                    sum_st  = ST_OK;
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = PH_BLOCK;
                    n_bidx  = '0;
                    n_crc   = '0;
                end
            end
            default: n_phase = PH_IDLE;
        endcase

        // early end of buffer overrides any payload byte on this step
        if (i_item.buffer_end && n_phase != PH_IDLE) begin
            do_pay  = 1'b0;
            do_sum  = 1'b1;
            sum_st  = ST_TRUNCATED;
            n_phase = PH_IDLE;
        end
    end

    // Result built from the updated frame state
    always_comb begin
        o_res     = '0;
        o_res_vld = do_sum || do_pay;
        if (do_sum) begin
            o_res.kind                = KIND_SUMMARY;
            o_res.status              = sum_st;
            o_res.source_address      = n_src;
            o_res.destination_address = n_dst;
            o_res.link_control        = n_ctl;
            o_res.is_response         = (n_hidx >= HIDX_W'(4)) && !n_ctl[7];
            o_res.header_crc_bad      = n_err[0];
            o_res.block_crc_bad       = n_err[1];
            o_res.first_fragment      = n_tb[0];
            o_res.final_fragment      = n_tb[1];
            o_res.user_data_count     = (n_hidx >= HIDX_W'(3) && n_len >= MIN_LENGTH)
                                        ? (n_len - MIN_LENGTH) : 8'd0;
        end else begin
            o_res.kind         = KIND_PAYLOAD;
            o_res.payload_byte = b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START0;
            r_hidx  <= '0;
            r_crc   <= '0;
            r_low   <= '0;
            r_len   <= '0;
            r_ctl   <= '0;
            r_dst   <= '0;
            r_src   <= '0;
            r_rem   <= '0;
            r_bidx  <= '0;
            r_err   <= '0;
            r_tb    <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_hidx  <= n_hidx;
            r_crc   <= n_crc;
            r_low   <= n_low;
            r_len   <= n_len;
            r_ctl   <= n_ctl;
            r_dst   <= n_dst;
            r_src   <= n_src;
            r_rem   <= n_rem;
            r_bidx  <= n_bidx;
            r_err   <= n_err;
            r_tb    <= n_tb;
        end
    end

`ifndef SYNTHESIS
    a_hidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hidx <= HIDX_W'(HEADER_BYTES))
        else $error("header index past header length");

    a_bidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bidx <= BIDX_W'(BLOCK_BYTES))
        else $error("block index past block length");

    a_block_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_BLOCK |-> r_rem != 8'd0)
        else $error("block phase with no user bytes left");

    a_summary_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && do_sum |=> r_phase == PH_IDLE)
        else $error("parser not idle after summary");
`endif

endmodule

// ===== sv/dnp3_link_frame_checker.sv =====
// DNP3 data link frame checker, top level: input stage, parser, result register.
// Depends on dnp3lfc_pkg, dnp3lfc_ifs and dnp3lfc_parser.
//
// Usage
//   i_frm carries the received buffer one byte per transfer. frame_begin on
//   a byte restarts the parser for a new buffer; buffer_end marks its last
//   byte. o_res carries results: a payload byte (kind 0) for each user data
//   byte after the transport header, and one summary (kind 1) per frame with
//   addresses, control byte, CRC error flags, FIR/FIN and a status.
//   Path: each byte is registered in the input register, and its result
//   in the result register.
//   Throughput: one byte per cycle while o_res is taken; the CRC-16/DNP
//   byte update and frame counters are combinational between the registers.
//   Stall: when o_res is not taken, the finished result holds in the result
//   register and one more byte is held in the input register; i_frm.ready
//   drops only when both are occupied.
//   Reset: synchronous, active low; clears both stages and puts the parser
//   in the wait-for-start state, so a first byte without frame_begin is
//   still taken as the start of a buffer.
module dnp3_link_frame_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    dnp3lfc_byte_if.sink   i_frm,
    dnp3lfc_res_if.source  o_res
);
    import dnp3lfc_pkg::*;

    logic     r_in_vld;
    t_in_item r_in;
    logic     r_out_vld;
    t_result  r_out;

    logic     w_step;
    logic     w_res_vld;
    t_result  w_res;

    // the parser moves when the result slot is free or being emptied
    assign w_step      = r_in_vld && (!r_out_vld || o_res.ready);
    assign i_frm.ready = !r_in_vld || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_frm.ready) begin
            r_in_vld <= i_frm.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frm.valid && i_frm.ready) begin
            r_in.data_byte   <= i_frm.data_byte;
            r_in.frame_begin <= i_frm.frame_begin;
            r_in.buffer_end  <= i_frm.buffer_end;
        end
    end

    dnp3lfc_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_item    (r_in),
        .o_res_vld (w_res_vld),
        .o_res     (w_res)
    );

    // result register: loads on a step that yields a result, clears on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step && w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid               = r_out_vld;
    assign o_res.kind                = r_out.kind;
    assign o_res.payload_byte        = r_out.payload_byte;
    assign o_res.status              = r_out.status;
    assign o_res.source_address      = r_out.source_address;
    assign o_res.destination_address = r_out.destination_address;
    assign o_res.link_control        = r_out.link_control;
    assign o_res.is_response         = r_out.is_response;
    assign o_res.header_crc_bad      = r_out.header_crc_bad;
    assign o_res.block_crc_bad       = r_out.block_crc_bad;
    assign o_res.first_fragment      = r_out.first_fragment;
    assign o_res.final_fragment      = r_out.final_fragment;
    assign o_res.user_data_count     = r_out.user_data_count;

`ifndef SYNTHESIS
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_res.ready |-> !w_step)
        else $error("parser stepped while result slot was blocked");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !o_res.ready |-> !i_frm.ready)
        else $error("input taken with both stages full");

    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_step |=> r_in_vld && $stable(r_in))
        else $error("unprocessed input byte lost");
`endif

endmodule
